>>> src/jdv_pkg.sv
// Shared types, codes and character helpers for the JSON document validator.
// Depends on nothing; imported by json_document_validator, not by jdv_nest_stack.
`default_nettype none
package jdv_pkg;

  localparam int unsigned StatW = 2;
  localparam int unsigned AccW  = 21;
  localparam int unsigned CntW  = 3;

  localparam logic [StatW-1:0] STAT_OK      = 2'd0;
  localparam logic [StatW-1:0] ERR_NONE     = 2'd0;
  localparam logic [StatW-1:0] ERR_ILLEGAL  = 2'd1;
  localparam logic [StatW-1:0] ERR_DEPTH    = 2'd2;
  localparam logic [StatW-1:0] STAT_PARTIAL = 2'd3;

  localparam logic [1:0] WORD_TRUE  = 2'd0;
  localparam logic [1:0] WORD_FALSE = 2'd1;
  localparam logic [1:0] WORD_NULL  = 2'd2;

  // Grammar states, one-hot. String sub-states are shared by values and keys.
  typedef enum logic [21:0] {
    ST_VALUE     = 22'd1 << 0,
    ST_ARR_FIRST = 22'd1 << 1,
    ST_OBJ_FIRST = 22'd1 << 2,
    ST_KEY       = 22'd1 << 3,
    ST_COLON     = 22'd1 << 4,
    ST_AFTER     = 22'd1 << 5,
    ST_S_CHR     = 22'd1 << 6,
    ST_S_ESC     = 22'd1 << 7,
    ST_S_HEX     = 22'd1 << 8,
    ST_S_UTF1    = 22'd1 << 9,
    ST_S_UTFN    = 22'd1 << 10,
    ST_S_LBS     = 22'd1 << 11,
    ST_S_LU      = 22'd1 << 12,
    ST_LIT       = 22'd1 << 13,
    ST_N_MINUS   = 22'd1 << 14,
    ST_N_ZERO    = 22'd1 << 15,
    ST_N_INT     = 22'd1 << 16,
    ST_N_DOT     = 22'd1 << 17,
    ST_N_FRAC    = 22'd1 << 18,
    ST_N_EXP     = 22'd1 << 19,
    ST_N_EXPSIGN = 22'd1 << 20,
    ST_N_EXPD    = 22'd1 << 21
  } jdv_state_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // Value of a hex digit; 16 marks a byte that is not one.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (is_digit(c)) v = 5'(c - 8'h30);
    else if (c >= "a" && c <= "f") v = 5'(c - 8'h57);
    else if (c >= "A" && c <= "F") v = 5'(c - 8'h37);
    return v;
  endfunction

  function automatic logic [CntW-1:0] word_len(input logic [1:0] w);
    logic [CntW-1:0] n;
    unique case (w)
      WORD_TRUE:  n = 3'd4;
      WORD_FALSE: n = 3'd5;
      WORD_NULL:  n = 3'd4;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] word_char(input logic [1:0] w, input logic [CntW-1:0] i);
    logic [39:0] s;
    unique case (w)
      WORD_TRUE:  s = {8'h00, "eurt"};
      WORD_FALSE: s = "eslaf";
      WORD_NULL:  s = {8'h00, "llun"};
      default:    s = 40'd0;
    endcase
    return (i < 3'd5) ? s[i*8 +: 8] : 8'h00;
  endfunction

endpackage
`default_nettype wire

>>> src/jdv_nest_stack.sv
// Nesting stack memory: one bit per level, 1 for object and 0 for array.
// Synchronous write, registered read; no package use.
`default_nettype none
module jdv_nest_stack #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = 5
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic              wr_bit,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic                   rd_bit
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
    rd_bit <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> src/json_document_validator.sv
// Top level of the JSON document validator: handshakes, grammar and error logic.
// Depends on jdv_pkg and instantiates jdv_nest_stack.
//
// Usage: the document arrives one byte per input transaction on in_valid /
// in_ready, with in_last_byte marking its final byte. Exactly one output
// transaction follows each final byte, carrying out_status: 0 success,
// 1 illegal document, 2 nesting too deep, 3 partial (the text ended inside
// a valid prefix). Other bytes produce no output transaction.
// Throughput is one byte per cycle while in_ready is high: the grammar step for a
// byte is done in the cycle it is accepted, and the top of the nesting stack is
// cached in a register while the memory keeps the level below it read out, so
// pops do not hold up the input. The status appears in the output register in
// the cycle after the final byte is accepted.
// The output register holds a status until it is taken; while it is full and
// out_ready is low, in_ready is low. When out_ready is high the next byte is
// taken in the same cycle the status leaves.
// Reset (rst_n low, synchronous) clears the grammar state, the error latch,
// out_valid and collections_only, but not out_status. The stack memory is not
// cleared: only levels written in the current document are ever used. After
// each final byte state, level, err, acc, cnt and hs take their reset values.
// cfg_we writes cfg_data into collections_only; write it only while idle.
`default_nettype none
module json_document_validator #(
  parameter int unsigned MAX_DEPTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              in_text_byte,
  input  wire logic                    in_last_byte,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [jdv_pkg::StatW-1:0]    out_status
);
  import jdv_pkg::*;

  localparam int unsigned LvlW  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AddrW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  jdv_state_t       state_r, state_nxt;
  logic             key_r, key_nxt;          // string being scanned is a key
  logic [1:0]       word_r, word_nxt;        // which literal is being matched
  logic [AccW-1:0]  acc_r, acc_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             hs_r, hs_nxt;
  logic [StatW-1:0] err_r, err_nxt;
  logic [LvlW-1:0]  level_r, level_nxt;
  logic             top_r, top_nxt;          // cached kind of the innermost level
  logic             co_r;
  logic             out_valid_r, out_valid_nxt;
  logic [StatW-1:0] out_status_r, out_status_nxt;

  logic             accept;
  logic [7:0]       c;
  logic [4:0]       hd;
  logic [15:0]      hex_acc;
  logic [CntW-1:0]  cnt_dec;
  logic             do_after, do_pop, do_push, push_obj;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic             below_bit;
  logic [StatW-1:0] status;
  logic             done_ok;

  assign accept     = in_valid && in_ready;
  assign in_ready   = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign c          = in_text_byte;
  assign hd         = hex_val(c);
  assign hex_acc    = {acc_r[11:0], hd[3:0]};
  assign cnt_dec    = cnt_r - 3'd1;

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    word_nxt  = word_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    hs_nxt    = hs_r;
    err_nxt   = err_r;
    level_nxt = level_r;
    top_nxt   = top_r;
    do_after  = 1'b0;
    do_pop    = 1'b0;
    do_push   = 1'b0;
    push_obj  = 1'b0;
    mem_we    = 1'b0;

    if (accept && err_r == ERR_NONE) begin
      unique case (state_r)
        ST_VALUE, ST_ARR_FIRST: begin
          if (is_ws(c)) begin
          end else if (c == "]" && state_r == ST_ARR_FIRST) begin
            do_pop = 1'b1;
          end else if (c == "{" || c == "[") begin
            do_push  = 1'b1;
            push_obj = (c == "{");
          end else if (level_r == '0 && co_r) begin
            err_nxt = ERR_ILLEGAL;
          end else begin
            hs_nxt  = 1'b0;
            cnt_nxt = 3'd1;
            if (c == "\"") begin
              state_nxt = ST_S_CHR;
              key_nxt   = 1'b0;
            end else if (c == "t") begin
              state_nxt = ST_LIT;
              word_nxt  = WORD_TRUE;
            end else if (c == "f") begin
              state_nxt = ST_LIT;
              word_nxt  = WORD_FALSE;
            end else if (c == "n") begin
              state_nxt = ST_LIT;
              word_nxt  = WORD_NULL;
            end else if (c == "-") begin
              state_nxt = ST_N_MINUS;
            end else if (c == "0") begin
              state_nxt = ST_N_ZERO;
            end else if (is_digit(c)) begin
              state_nxt = ST_N_INT;
            end else begin
              err_nxt = ERR_ILLEGAL;
            end
          end
        end
        ST_OBJ_FIRST, ST_KEY: begin
          if (is_ws(c)) begin
          end else if (c == "\"") begin
            hs_nxt    = 1'b0;
            key_nxt   = 1'b1;
            state_nxt = ST_S_CHR;
          end else if (c == "}" && state_r == ST_OBJ_FIRST) begin
            do_pop = 1'b1;
          end else begin
            err_nxt = ERR_ILLEGAL;
          end
        end
        ST_COLON: begin
          if (is_ws(c)) begin
          end else if (c == ":") begin
            state_nxt = ST_VALUE;
          end else begin
            err_nxt = ERR_ILLEGAL;
          end
        end
        ST_AFTER: begin
          do_after = 1'b1;
        end
        ST_S_CHR: begin
          if (c == "\"") begin
            state_nxt = key_r ? ST_COLON : ST_AFTER;
          end else if (c == "\\") begin
            state_nxt = ST_S_ESC;
          end else if (c < 8'h20) begin
            err_nxt = ERR_ILLEGAL;
          end else if (c < 8'h80) begin
          end else if (c > 8'hC1 && c < 8'hE0) begin
            acc_nxt   = AccW'(c[4:0]);
            cnt_nxt   = 3'd1;
            state_nxt = ST_S_UTF1;
          end else if (c >= 8'hE0 && c < 8'hF0) begin
            acc_nxt   = AccW'(c[3:0]);
            cnt_nxt   = 3'd2;
            state_nxt = ST_S_UTF1;
          end else if (c >= 8'hF0 && c < 8'hF5) begin
            acc_nxt   = AccW'(c[2:0]);
            cnt_nxt   = 3'd3;
            state_nxt = ST_S_UTF1;
          end else begin
            err_nxt = ERR_ILLEGAL;
          end
        end
        ST_S_ESC, ST_S_LU: begin
          if (c == "u") begin
            state_nxt = ST_S_HEX;
            cnt_nxt   = 3'd4;
            acc_nxt   = '0;
          end else if (state_r == ST_S_ESC &&
                       (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                        c == "n" || c == "r" || c == "t" || (c >= 8'h01 && c < 8'h20))) begin
            state_nxt = ST_S_CHR;
          end else begin
            err_nxt = ERR_ILLEGAL;
          end
        end
        ST_S_HEX: begin
          if (hd[4] || cnt_r == '0) begin
            err_nxt = ERR_ILLEGAL;
          end else begin
            acc_nxt = AccW'(hex_acc);
            cnt_nxt = cnt_dec;
            if (cnt_dec == '0) begin
              if (hs_r) begin
                if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                  hs_nxt    = 1'b0;
                  state_nxt = ST_S_CHR;
                end else begin
                  err_nxt = ERR_ILLEGAL;
                end
              end else if (hex_acc == 16'h0000 ||
                           (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF)) begin
                err_nxt = ERR_ILLEGAL;
              end else if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                hs_nxt    = 1'b1;
                state_nxt = ST_S_LBS;
              end else begin
                state_nxt = ST_S_CHR;
              end
            end
          end
        end
        ST_S_UTF1, ST_S_UTFN: begin
          // The first continuation byte also enforces shortest form,
          // the surrogate gap and the upper code point limit.
          if (c[7:6] != 2'b10 || cnt_r == '0) begin
            err_nxt = ERR_ILLEGAL;
          end else if (state_r == ST_S_UTF1 && cnt_r == 3'd2 &&
                       ((acc_r == '0 && c < 8'hA0) || (acc_r == AccW'(4'hD) && c >= 8'hA0))) begin
            err_nxt = ERR_ILLEGAL;
          end else if (state_r == ST_S_UTF1 && cnt_r == 3'd3 &&
                       ((acc_r == '0 && c < 8'h90) || (acc_r == AccW'(3'd4) && c >= 8'h90))) begin
            err_nxt = ERR_ILLEGAL;
          end else begin
            acc_nxt   = {acc_r[AccW-7:0], c[5:0]};
            cnt_nxt   = cnt_dec;
            state_nxt = (cnt_dec == '0) ? ST_S_CHR : ST_S_UTFN;
          end
        end
        ST_S_LBS: begin
          if (c == "\\") begin
            state_nxt = ST_S_LU;
          end else begin
            err_nxt = ERR_ILLEGAL;
          end
        end
        ST_LIT: begin
          if (cnt_r >= word_len(word_r) || word_char(word_r, cnt_r) != c) begin
            err_nxt = ERR_ILLEGAL;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
            if (cnt_r + 3'd1 == word_len(word_r)) begin
              state_nxt = ST_AFTER;
            end
          end
        end
        ST_N_MINUS: begin
          if (c == "0") state_nxt = ST_N_ZERO;
          else if (is_digit(c)) state_nxt = ST_N_INT;
          else err_nxt = ERR_ILLEGAL;
        end
        ST_N_DOT: begin
          if (is_digit(c)) state_nxt = ST_N_FRAC;
          else err_nxt = ERR_ILLEGAL;
        end
        ST_N_EXP: begin
          if (c == "+" || c == "-") state_nxt = ST_N_EXPSIGN;
          else if (is_digit(c)) state_nxt = ST_N_EXPD;
          else err_nxt = ERR_ILLEGAL;
        end
        ST_N_EXPSIGN: begin
          if (is_digit(c)) state_nxt = ST_N_EXPD;
          else err_nxt = ERR_ILLEGAL;
        end
        ST_N_ZERO, ST_N_INT, ST_N_FRAC, ST_N_EXPD: begin
          // A byte that cannot extend the number ends it and is then
          // handled as the byte after a value.
          if (is_digit(c) && state_r != ST_N_ZERO) begin
          end else if (c == "." && (state_r == ST_N_ZERO || state_r == ST_N_INT)) begin
            state_nxt = ST_N_DOT;
          end else if ((c == "e" || c == "E") && state_r != ST_N_EXPD) begin
            state_nxt = ST_N_EXP;
          end else begin
            state_nxt = ST_AFTER;
            do_after  = 1'b1;
          end
        end
        default: begin
          err_nxt = ERR_ILLEGAL;
        end
      endcase

      if (do_after) begin
        if (is_ws(c)) begin
        end else if (level_r == '0) begin
          err_nxt = ERR_ILLEGAL;
        end else if (c == ",") begin
          state_nxt = top_r ? ST_KEY : ST_VALUE;
        end else if ((c == "}" && top_r) || (c == "]" && !top_r)) begin
          do_pop = 1'b1;
        end else begin
          err_nxt = ERR_ILLEGAL;
        end
      end

      if (do_pop) begin
        if (level_r != '0) level_nxt = level_r - 1'b1;
        state_nxt = ST_AFTER;
        top_nxt   = below_bit;
      end

      if (do_push) begin
        if (level_r >= LvlW'(MAX_DEPTH)) begin
          err_nxt = ERR_DEPTH;
        end else begin
          mem_we    = 1'b1;
          level_nxt = level_r + 1'b1;
          top_nxt   = push_obj;
          state_nxt = push_obj ? ST_OBJ_FIRST : ST_ARR_FIRST;
        end
      end
    end

    // Status of the document as it stands after this byte.
    done_ok = (state_nxt == ST_AFTER) || (state_nxt == ST_N_ZERO) ||
              (state_nxt == ST_N_INT) || (state_nxt == ST_N_FRAC) ||
              (state_nxt == ST_N_EXPD);
    if (err_nxt != ERR_NONE) status = err_nxt;
    else if (level_nxt == '0 && done_ok) status = STAT_OK;
    else status = STAT_PARTIAL;

    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    if (accept && in_last_byte) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status;
      state_nxt      = ST_VALUE;
      level_nxt      = '0;
      acc_nxt        = '0;
      cnt_nxt        = '0;
      hs_nxt         = 1'b0;
      err_nxt        = ERR_NONE;
    end
  end

  // Keep the entry below the top read out: address is two under the next level.
  assign mem_waddr = AddrW'(level_r);
  assign mem_raddr = (level_nxt >= LvlW'(2)) ? AddrW'(level_nxt - LvlW'(2)) : '0;

  jdv_nest_stack #(
    .DEPTH  (MAX_DEPTH),
    .ADDR_W (AddrW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_bit  (push_obj),
    .rd_addr (mem_raddr),
    .rd_bit  (below_bit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_VALUE;
      key_r       <= 1'b0;
      word_r      <= WORD_TRUE;
      acc_r       <= '0;
      cnt_r       <= '0;
      hs_r        <= 1'b0;
      err_r       <= ERR_NONE;
      level_r     <= '0;
      top_r       <= 1'b0;
      co_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_r       <= key_nxt;
      word_r      <= word_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      hs_r        <= hs_nxt;
      err_r       <= err_nxt;
      level_r     <= level_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) co_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
  end

`ifndef SYNTH
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LvlW'(MAX_DEPTH))
    else $error("nesting level beyond MAX_DEPTH");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_byte) |=>
      (level_r == '0 && err_r == ERR_NONE && state_r == ST_VALUE && out_valid_r))
    else $error("document state not cleared after final byte");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid_r && !out_ready))
    else $error("input taken while a status is stalled");

  a_error_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ERR_NONE && !(accept && in_last_byte)) |=>
      ($stable(level_r) && $stable(state_r) && $stable(err_r)))
    else $error("state changed after an error was latched");
`endif

endmodule
`default_nettype wire
